/* rtl/core/pcar_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pcar_pkg;

    // Width of the configuration register index
    localparam int CFG_INDEX_W = 8;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Enable bit of the 0xCF8 address word
    localparam logic CF8_ENABLE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_ENABLE = 8'd0,
        CFG_WINDOW_BASE   = 8'd1,
        CFG_FIRST_BUS     = 8'd2,
        CFG_LAST_BUS      = 8'd3
    } cfg_index_t;

    // Route taken by an access
    typedef enum logic [1:0] {
        PATH_WINDOW = 2'd0,
        PATH_PORT   = 2'd1,
        PATH_NONE   = 2'd2
    } path_t;

    // Configuration register set
    typedef struct packed {
        logic        window_enable;
        logic [63:0] window_base;
        logic [7:0]  first_bus;
        logic [7:0]  bus_limit;
    } cfg_t;

    // One configuration access
    typedef struct packed {
        logic        opcode;
        logic [7:0]  bus_number;
        logic [4:0]  slot_number;
        logic [2:0]  function_number;
        logic [15:0] register_offset;
        logic        map_available;
    } req_t;

    // One routing result
    typedef struct packed {
        path_t       path;
        logic [63:0] window_address;
        logic [31:0] port_address;
        logic        map_request;
        logic [63:0] map_base;
        logic        all_ones_read;
    } rsp_t;

    // Lookup of the per-bus mapped store
    typedef struct packed {
        logic in_store;
        logic mapped;
    } map_status_t;

endpackage

`default_nettype wire

/* rtl/core/pcar_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Access word channel
interface pcar_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  bus_number;
    logic [4:0]  slot_number;
    logic [2:0]  function_number;
    logic [15:0] register_offset;
    logic        map_available;

    modport source (
        output valid, opcode, bus_number, slot_number, function_number,
               register_offset, map_available,
        input  ready
    );
    modport sink (
        input  valid, opcode, bus_number, slot_number, function_number,
               register_offset, map_available,
        output ready
    );
endinterface

// Result word channel
interface pcar_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  path;
    logic [63:0] window_address;
    logic [31:0] port_address;
    logic        map_request;
    logic [63:0] map_base;
    logic        all_ones_read;

    modport source (
        output valid, path, window_address, port_address, map_request,
               map_base, all_ones_read,
        input  ready
    );
    modport sink (
        input  valid, path, window_address, port_address, map_request,
               map_base, all_ones_read,
        output ready
    );
endinterface

// Configuration write channel
interface pcar_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/pcar_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module pcar_cfg_regs
    import pcar_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pcar_cfg_if.sink    cfg,
    output cfg_t        regs,
    output logic        clear_map
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;
    assign clear_map = wr_en;
    assign regs      = cfg_reg;

    // Register decode; unknown indexes leave the set untouched
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_WINDOW_ENABLE: cfg_next.window_enable = cfg.data[0];
                CFG_WINDOW_BASE:   cfg_next.window_base   = cfg.data;
                CFG_FIRST_BUS:     cfg_next.first_bus     = cfg.data[7:0];
                CFG_LAST_BUS:      cfg_next.bus_limit     = cfg.data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pcar_map_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module pcar_map_store
    import pcar_pkg::*;
#(
    parameter int BUS_COUNT = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       clear,
    input  wire logic [7:0] bus,
    input  wire logic       set,
    output map_status_t     status
);

    localparam int IDX_W = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;

    logic [BUS_COUNT-1:0] mapped_reg;
    logic [BUS_COUNT-1:0] mapped_next;
    logic [IDX_W-1:0]     bus_idx;
    logic                 in_store;

    // Bus lookup; buses past the store read as not covered
    assign in_store        = ({1'b0, bus} < 9'(BUS_COUNT));
    assign bus_idx         = bus[IDX_W-1:0];
    assign status.in_store = in_store;
    assign status.mapped   = in_store && mapped_reg[bus_idx];

    // Mark on first mapping, wipe on any register write
    always_comb
    begin
        mapped_next = mapped_reg;
        if (clear)
        begin
            mapped_next = '0;
        end
        else if (set && in_store)
        begin
            mapped_next[bus_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapped_reg <= '0;
        end
        else
        begin
            mapped_reg <= mapped_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pcar_route.sv */
`timescale 1ns / 1ps
`default_nettype none

module pcar_route
    import pcar_pkg::*;
(
    input  cfg_t        regs,
    input  req_t        item,
    input  map_status_t status,
    output rsp_t        result,
    output logic        set_mapped
);

    logic        window_hit;
    logic        window_ok;
    logic        port_ok;
    logic [7:0]  bus_delta;
    logic [63:0] bus_window;
    logic [63:0] win_addr;

    // Window eligibility: enabled, bus in range, offset within 4 KiB
    assign window_hit = regs.window_enable
                     && (item.bus_number >= regs.first_bus)
                     && (item.bus_number <= regs.bus_limit)
                     && (item.register_offset[15:12] == 4'd0)
                     && status.in_store;

    assign window_ok  = window_hit && (status.mapped || item.map_available);
    assign set_mapped = window_hit && !status.mapped && item.map_available;
    assign port_ok    = (item.register_offset[15:8] == 8'd0);

    // Window addresses: bus at bit 20, slot 15, function 12, dword offset
    assign bus_delta  = item.bus_number - regs.first_bus;
    assign bus_window = regs.window_base + {36'd0, bus_delta, 20'd0};
    assign win_addr   = regs.window_base + {36'd0, bus_delta, item.slot_number,
                                            item.function_number,
                                            item.register_offset[11:2], 2'b00};

    // Result word
    always_comb
    begin
        result = '0;
        if (window_ok)
        begin
            result.path           = PATH_WINDOW;
            result.window_address = win_addr;
            result.map_request    = set_mapped;
            result.map_base       = set_mapped ? bus_window : 64'd0;
        end
        else if (port_ok)
        begin
            result.path         = PATH_PORT;
            result.port_address = {CF8_ENABLE, 7'd0, item.bus_number,
                                   item.slot_number, item.function_number,
                                   item.register_offset[7:2], 2'b00};
        end
        else
        begin
            result.path          = PATH_NONE;
            result.all_ones_read = (item.opcode == OP_READ);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pci_config_access_router.sv */
`timescale 1ns / 1ps
`default_nettype none

// Routes PCI configuration accesses to the memory-mapped (ECAM-style) window
// or to the 0xCF8 port address, or reports no path with an all-ones read.
// One access word is taken per clock while the result register is free or
// being taken; each result passes through the input register, then route
// logic into the result register, and a full result register that is not
// taken holds back one further word in the input register. The per-bus mapped bitmap is read and updated in the
// route stage, so back-to-back accesses to the same bus see each other's
// mapping. Register writes clear the bitmap and must be issued while idle.
module pci_config_access_router
    import pcar_pkg::*;
#(
    parameter int BUS_COUNT = 256
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pcar_req_if.sink    req,
    pcar_rsp_if.source  rsp,
    pcar_cfg_if.sink    cfg
);

    cfg_t        regs;
    logic        clear_map;
    map_status_t status;
    rsp_t        route_result;
    logic        route_set;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    req_t        s1_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    rsp_t        out_item_reg;
    logic        advance;
    logic        req_fire;

    // Configuration registers
    pcar_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .regs      (regs),
        .clear_map (clear_map)
    );

    // Per-bus mapped bitmap
    pcar_map_store #(
        .BUS_COUNT (BUS_COUNT)
    ) u_map_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (clear_map),
        .bus    (s1_item_reg.bus_number),
        .set    (route_set && advance && s1_valid_reg),
        .status (status)
    );

    // Route decision
    pcar_route u_route (
        .regs       (regs),
        .item       (s1_item_reg),
        .status     (status),
        .result     (route_result),
        .set_mapped (route_set)
    );

    // Pipeline flow control
    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_item_reg.opcode          <= req.opcode;
            s1_item_reg.bus_number      <= req.bus_number;
            s1_item_reg.slot_number     <= req.slot_number;
            s1_item_reg.function_number <= req.function_number;
            s1_item_reg.register_offset <= req.register_offset;
            s1_item_reg.map_available   <= req.map_available;
        end
        if (advance && s1_valid_reg)
        begin
            out_item_reg <= route_result;
        end
    end

    // Result word
    assign rsp.valid          = out_valid_reg;
    assign rsp.path           = out_item_reg.path;
    assign rsp.window_address = out_item_reg.window_address;
    assign rsp.port_address   = out_item_reg.port_address;
    assign rsp.map_request    = out_item_reg.map_request;
    assign rsp.map_base       = out_item_reg.map_base;
    assign rsp.all_ones_read  = out_item_reg.all_ones_read;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import pcar_pkg::*;

    localparam int BUS_COUNT   = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int BLOCK_WORDS = 100;
    localparam int HOLD_CYCLES = 80;

    // First register index that the block does not implement
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 8'd4;

    // One row of the directed sequence: a register write or an access word
    typedef struct {
        bit                     is_reg;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [63:0]            reg_value;
        req_t                   access;
        bit                     known;
        rsp_t                   result;
    } route_case_t;

    logic clk;
    logic rst_n;

    pcar_req_if req_ch ();
    pcar_rsp_if rsp_ch ();
    pcar_cfg_if cfg_ch ();

    pci_config_access_router #(
        .BUS_COUNT (BUS_COUNT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow of the register set and of the per-bus mapped bitmap
    cfg_t                 router_cfg;
    logic [BUS_COUNT-1:0] mapped_buses;
    logic [7:0]           range_first;
    logic [7:0]           range_last;

    rsp_t        expected_routes[$];
    route_case_t route_cases[$];

    // Expected result typed in for the word on offer, where there is one
    bit   pending_known;
    rsp_t pending_result;

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    bit hold_done;
    int hold_left;
    int cycle_count;

    int mismatches;
    int window_routes;
    int port_routes;
    int dead_routes;
    int map_requests;
    int reg_writes;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Routing predictor; updates the mapped bitmap as the block would
    function automatic rsp_t route_access(input req_t a);
        rsp_t        r;
        logic [63:0] bus_window;
        logic        routed;
        r          = '0;
        r.path     = PATH_NONE;
        routed     = 1'b0;
        bus_window = '0;
        if (router_cfg.window_enable && a.bus_number >= router_cfg.first_bus
            && a.bus_number <= router_cfg.bus_limit && a.register_offset <= 16'h0FFF
            && a.bus_number < BUS_COUNT)
        begin
            bus_window = router_cfg.window_base
                       + (64'(a.bus_number - router_cfg.first_bus) << 20);
            if (mapped_buses[a.bus_number])
            begin
                routed = 1'b1;
            end
            else if (a.map_available)
            begin
                mapped_buses[a.bus_number] = 1'b1;
                r.map_request = 1'b1;
                r.map_base    = bus_window;
                routed        = 1'b1;
            end
            if (routed)
            begin
                r.path           = PATH_WINDOW;
                r.window_address = bus_window + (64'(a.slot_number) << 15)
                                 + (64'(a.function_number) << 12)
                                 + 64'(a.register_offset & 16'h0FFC);
            end
        end
        if (!routed)
        begin
            if (a.register_offset < 16'd256)
            begin
                r.path         = PATH_PORT;
                r.port_address = {CF8_ENABLE, 7'd0, a.bus_number, a.slot_number,
                                  a.function_number, a.register_offset[7:2], 2'b00};
            end
            else
            begin
                r.path          = PATH_NONE;
                r.all_ones_read = (a.opcode == OP_READ);
            end
        end
        return r;
    endfunction

    // Register write into the shadow; any write wipes the bitmap
    function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [63:0] value);
        mapped_buses = '0;
        case (idx)
            CFG_WINDOW_ENABLE: router_cfg.window_enable = value[0];
            CFG_WINDOW_BASE:   router_cfg.window_base   = value;
            CFG_FIRST_BUS:     router_cfg.first_bus     = value[7:0];
            CFG_LAST_BUS:      router_cfg.bus_limit     = value[7:0];
            default: ;
        endcase
    endfunction

    // Field-by-field comparison of the result word on the bus
    function automatic void check_route(input rsp_t want);
        if (rsp_ch.path !== want.path)
        begin
            $error("path: expected %0d, got %0d", want.path, rsp_ch.path);
            mismatches++;
        end
        if (rsp_ch.window_address !== want.window_address)
        begin
            $error("window_address: expected %h, got %h",
                   want.window_address, rsp_ch.window_address);
            mismatches++;
        end
        if (rsp_ch.port_address !== want.port_address)
        begin
            $error("port_address: expected %h, got %h",
                   want.port_address, rsp_ch.port_address);
            mismatches++;
        end
        if (rsp_ch.map_request !== want.map_request)
        begin
            $error("map_request: expected %0d, got %0d",
                   want.map_request, rsp_ch.map_request);
            mismatches++;
        end
        if (rsp_ch.map_base !== want.map_base)
        begin
            $error("map_base: expected %h, got %h", want.map_base, rsp_ch.map_base);
            mismatches++;
        end
        if (rsp_ch.all_ones_read !== want.all_ones_read)
        begin
            $error("all_ones_read: expected %0d, got %0d",
                   want.all_ones_read, rsp_ch.all_ones_read);
            mismatches++;
        end
    endfunction

    // Monitor: results are checked before new words are predicted
    always @(posedge clk)
    begin : route_monitor
        req_t seen;
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_routes.size() == 0)
                begin
                    $error("result word with no access outstanding");
                    mismatches++;
                end
                else
                begin
                    check_route(expected_routes.pop_front());
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                apply_reg_write(cfg_ch.index, cfg_ch.data);
                reg_writes++;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen.opcode          = req_ch.opcode;
                seen.bus_number      = req_ch.bus_number;
                seen.slot_number     = req_ch.slot_number;
                seen.function_number = req_ch.function_number;
                seen.register_offset = req_ch.register_offset;
                seen.map_available   = req_ch.map_available;
                want = route_access(seen);
                if (pending_known)
                    want = pending_result;
                expected_routes.push_back(want);
                case (want.path)
                    PATH_WINDOW: window_routes++;
                    PATH_PORT:   port_routes++;
                    default:     dead_routes++;
                endcase
                if (want.map_request)
                    map_requests++;
            end
        end
    end

    // Result sink: random back-pressure, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic req_t mk_access(input logic op, input logic [7:0] bus,
                                       input logic [4:0] slot, input logic [2:0] fn,
                                       input logic [15:0] off, input logic avail);
        req_t a;
        a.opcode          = op;
        a.bus_number      = bus;
        a.slot_number     = slot;
        a.function_number = fn;
        a.register_offset = off;
        a.map_available   = avail;
        return a;
    endfunction

    function automatic rsp_t mk_result(input path_t p, input logic [63:0] waddr,
                                       input logic [31:0] paddr, input logic mreq,
                                       input logic [63:0] mbase, input logic ones);
        rsp_t r;
        r.path           = p;
        r.window_address = waddr;
        r.port_address   = paddr;
        r.map_request    = mreq;
        r.map_base       = mbase;
        r.all_ones_read  = ones;
        return r;
    endfunction

    function automatic void add_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [63:0] value);
        route_case_t c;
        c           = '{default: '0};
        c.is_reg    = 1'b1;
        c.reg_index = idx;
        c.reg_value = value;
        route_cases.push_back(c);
    endfunction

    function automatic void add_access(input req_t a);
        route_case_t c;
        c        = '{default: '0};
        c.access = a;
        route_cases.push_back(c);
    endfunction

    function automatic void add_known(input req_t a, input rsp_t r);
        route_case_t c;
        c        = '{default: '0};
        c.access = a;
        c.known  = 1'b1;
        c.result = r;
        route_cases.push_back(c);
    endfunction

    // Random access word, mostly aimed at the current bus window
    function automatic req_t random_access();
        req_t a;
        a.opcode          = 1'($urandom_range(1));
        a.slot_number     = 5'($urandom_range(31));
        a.function_number = 3'($urandom_range(7));
        a.map_available   = ($urandom_range(3) != 0);
        if (range_first <= range_last && $urandom_range(9) < 8)
            a.bus_number = 8'($urandom_range(range_last, range_first));
        else
            a.bus_number = 8'($urandom_range(255));
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: a.register_offset = 16'($urandom_range(16'h0FFF));
            6, 7:             a.register_offset = 16'($urandom_range(255));
            8:                a.register_offset = 16'($urandom_range(16'hFFFF));
            default:
            begin
                case ($urandom_range(3))
                    0:       a.register_offset = 16'h0FFF;
                    1:       a.register_offset = 16'h1000;
                    2:       a.register_offset = 16'h0100;
                    default: a.register_offset = 16'hFFFF;
                endcase
            end
        endcase
        return a;
    endfunction

    // Offer one access word; valid stays high after the handshake
    task automatic offer_access(input req_t a, input bit known, input rsp_t r);
        cfg_ch.valid <= 1'b0;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.opcode          <= a.opcode;
        req_ch.bus_number      <= a.bus_number;
        req_ch.slot_number     <= a.slot_number;
        req_ch.function_number <= a.function_number;
        req_ch.register_offset <= a.register_offset;
        req_ch.map_available   <= a.map_available;
        pending_known          <= known;
        pending_result         <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    // Stop offering and wait until every result has come back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_routes.size() != 0)
            @(posedge clk);
    endtask

    // New random settings, extremes included
    task automatic reconfigure();
        logic [63:0] base;
        logic [63:0] scratch;
        logic [7:0]  lo;
        logic [7:0]  hi;
        wait_idle();
        case ($urandom_range(5))
            0:       base = '0;
            1:       base = '1;
            2:       base = 64'hFFFF_FFFF_FFF0_0000;
            default: base = {$urandom, $urandom};
        endcase
        case ($urandom_range(7))
            0:
            begin
                lo = 8'h00;
                hi = 8'hFF;
            end
            1:
            begin
                lo = 8'($urandom_range(255));
                hi = 8'($urandom_range(255));
            end
            2:
            begin
                lo = 8'hFF;
                hi = 8'hFF;
            end
            default:
            begin
                lo = 8'($urandom_range(255));
                hi = lo + 8'($urandom_range(15));
            end
        endcase
        range_first = lo;
        range_last  = hi;
        scratch     = {$urandom, $urandom};
        scratch[0]  = ($urandom_range(7) != 0);
        write_reg(CFG_WINDOW_ENABLE, scratch);
        write_reg(CFG_WINDOW_BASE, base);
        scratch      = {$urandom, $urandom};
        scratch[7:0] = lo;
        write_reg(CFG_FIRST_BUS, scratch);
        scratch      = {$urandom, $urandom};
        scratch[7:0] = hi;
        write_reg(CFG_LAST_BUS, scratch);
        if ($urandom_range(3) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(255, CFG_INDEX_SPARE)),
                      {$urandom, $urandom});
    endtask

    // Stimulus
    initial
    begin
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.opcode          = OP_READ;
        req_ch.bus_number      = '0;
        req_ch.slot_number     = '0;
        req_ch.function_number = '0;
        req_ch.register_offset = '0;
        req_ch.map_available   = 1'b0;
        rsp_ch.ready           = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = CFG_WINDOW_ENABLE;
        cfg_ch.data            = '0;
        router_cfg             = '0;
        mapped_buses           = '0;
        range_first            = 8'h00;
        range_last             = 8'h00;
        pending_known          = 1'b0;
        pending_result         = '0;
        hold_req               = 1'b0;
        hold_done              = 1'b0;
        hold_left              = 0;
        mismatches             = 0;
        window_routes          = 0;
        port_routes            = 0;
        dead_routes            = 0;
        map_requests           = 0;
        reg_writes             = 0;
        tx_idle_pct            = 16;
        rx_idle_pct            = 74;

        // After reset the window is off: port or no path only
        add_known(mk_access(OP_READ, 8'h00, 5'd0, 3'd0, 16'h0000, 1'b0),
                  mk_result(PATH_PORT, '0, 32'h8000_0000, 1'b0, '0, 1'b0));
        add_known(mk_access(OP_READ, 8'hFF, 5'd31, 3'd7, 16'h00FF, 1'b1),
                  mk_result(PATH_PORT, '0, 32'h80FF_FFFC, 1'b0, '0, 1'b0));
        add_known(mk_access(OP_READ, 8'h12, 5'd3, 3'd2, 16'h0100, 1'b1),
                  mk_result(PATH_NONE, '0, '0, 1'b0, '0, 1'b1));
        add_known(mk_access(OP_WRITE, 8'hFF, 5'd31, 3'd7, 16'hFFFF, 1'b1),
                  mk_result(PATH_NONE, '0, '0, 1'b0, '0, 1'b0));

        // Whole bus range at base zero
        add_reg(CFG_WINDOW_ENABLE, 64'd1);
        add_reg(CFG_WINDOW_BASE, 64'd0);
        add_reg(CFG_FIRST_BUS, 64'h00);
        add_reg(CFG_LAST_BUS, 64'hFF);
        add_known(mk_access(OP_READ, 8'h00, 5'd0, 3'd0, 16'h0000, 1'b1),
                  mk_result(PATH_WINDOW, '0, '0, 1'b1, '0, 1'b0));
        add_known(mk_access(OP_WRITE, 8'h00, 5'd31, 3'd7, 16'h0FFF, 1'b0),
                  mk_result(PATH_WINDOW, 64'h000F_FFFC, '0, 1'b0, '0, 1'b0));
        // Mapping not available on an unmapped bus, then offset too large
        add_access(mk_access(OP_READ, 8'h05, 5'd9, 3'd1, 16'h0010, 1'b0));
        add_access(mk_access(OP_WRITE, 8'h05, 5'd9, 3'd1, 16'h0200, 1'b0));
        add_access(mk_access(OP_READ, 8'h05, 5'd9, 3'd1, 16'h1000, 1'b1));
        add_access(mk_access(OP_READ, 8'h05, 5'd9, 3'd1, 16'h0FFF, 1'b1));
        add_access(mk_access(OP_READ, 8'hFF, 5'd0, 3'd0, 16'h0000, 1'b1));

        // Base near the top of the address space: sums wrap
        add_reg(CFG_WINDOW_BASE, 64'hFFFF_FFFF_FFF0_0000);
        add_reg(CFG_FIRST_BUS, 64'h10);
        add_reg(CFG_LAST_BUS, 64'h20);
        add_access(mk_access(OP_WRITE, 8'h10, 5'd31, 3'd7, 16'h0FFC, 1'b1));
        add_access(mk_access(OP_READ, 8'h20, 5'd0, 3'd0, 16'h0000, 1'b1));
        add_access(mk_access(OP_READ, 8'h0F, 5'd1, 3'd1, 16'h0044, 1'b1));
        add_access(mk_access(OP_READ, 8'h21, 5'd1, 3'd1, 16'h0400, 1'b1));

        // Inverted bus range: the window is never used
        add_reg(CFG_FIRST_BUS, 64'h80);
        add_reg(CFG_LAST_BUS, 64'h40);
        add_access(mk_access(OP_READ, 8'h60, 5'd2, 3'd3, 16'h0000, 1'b1));
        add_access(mk_access(OP_READ, 8'h60, 5'd2, 3'd3, 16'h0800, 1'b1));

        // A write to an unused index still wipes the bitmap
        add_reg(CFG_FIRST_BUS, 64'h00);
        add_access(mk_access(OP_READ, 8'h20, 5'd4, 3'd5, 16'h0030, 1'b1));
        add_access(mk_access(OP_READ, 8'h20, 5'd4, 3'd5, 16'h0034, 1'b0));
        add_reg(CFG_INDEX_SPARE, 64'hDEAD_BEEF_0000_0001);
        add_access(mk_access(OP_READ, 8'h20, 5'd4, 3'd5, 16'h0038, 1'b0));
        add_reg(CFG_WINDOW_ENABLE, 64'd0);
        add_access(mk_access(OP_READ, 8'h20, 5'd4, 3'd5, 16'h0038, 1'b1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sequence
        foreach (route_cases[i])
        begin
            if (route_cases[i].is_reg)
            begin
                if (i == 0 || !route_cases[i-1].is_reg)
                    wait_idle();
                write_reg(route_cases[i].reg_index, route_cases[i].reg_value);
            end
            else
            begin
                offer_access(route_cases[i].access, route_cases[i].known,
                             route_cases[i].result);
            end
        end

        // Random phases: slow receiver, then slow sender, then full rate
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 74 : 0;
            rx_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 16 : 0;
            for (int blk = 0; blk < 5; blk++)
            begin
                reconfigure();
                if (phase == 2 && blk == 0)
                    hold_req = 1'b1;
                for (int n = 0; n < BLOCK_WORDS; n++)
                    offer_access(random_access(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Routed %0d accesses: %0d window, %0d port, %0d no path, %0d map requests",
                 window_routes + port_routes + dead_routes, window_routes, port_routes,
                 dead_routes, map_requests);
        $display("Register writes: %0d, result mismatches: %0d", reg_writes, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
